// File: hw/rtl/itrd_pkg.sv
`timescale 1ns / 1ps

package itrd_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_BASE_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int SYM_W      = 8;
  localparam int ALPHA_SYMS = 16;
  localparam int SYM_IDX_W  = 4;
  localparam int RADIX_W    = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Bits of the magnitude consumed by the divider in one cycle.
  localparam int STEP_BITS = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

  // Character codes.
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

  // Smallest usable radix.
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } itrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic chunk_last;
    logic quot_zero;
    logic out_free;
    logic one_left;
  } itrd_sts_t;

endpackage

// File: hw/rtl/itrd_ctrl.sv
`timescale 1ns / 1ps

module itrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                cfg_valid,
  input  itrd_pkg::itrd_sts_t sts,
  output itrd_pkg::itrd_cmd_t cmd,
  output logic                in_ready,
  output logic                cfg_ready
);
  import itrd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // A configuration write takes precedence over a new word.
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (in_valid && !cfg_valid && sts.alpha_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.chunk_last && sts.quot_zero) begin
          state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/itrd_dp.sv
`timescale 1ns / 1ps

module itrd_dp #(
  parameter int MAX_BASE   = itrd_pkg::MAX_BASE_DEF,
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [VALUE_BITS-1:0]          in_value,
  input  logic                                  out_ready,
  input  itrd_pkg::itrd_cmd_t                   cmd,
  output itrd_pkg::itrd_sts_t                   sts,
  output logic                                  out_valid,
  output logic [itrd_pkg::SYM_W-1:0]            out_symbol,
  output logic                                  out_last
);
  import itrd_pkg::*;

  localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_W   = CHUNKS * STEP_BITS;
  localparam int CHUNK_W = $clog2(CHUNKS + 1);
  localparam int DIG_W   = $clog2(MAX_BASE);
  localparam int DEPTH   = VALUE_BITS;
  localparam int DCNT_W  = $clog2(DEPTH + 1);

  // Configuration registers.
  logic [RADIX_W-1:0]    base_size_r;
  logic [CFG_DATA_W-1:0] alpha_low_r;
  logic [CFG_DATA_W-1:0] alpha_high_r;

  // Conversion state.
  logic [MAG_W-1:0]   mag_r;
  logic [MAG_W-1:0]   mag_nxt;
  logic [DIG_W-1:0]   rem_r;
  logic [DIG_W-1:0]   rem_nxt;
  logic               neg_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [DIG_W-1:0]   stack_r [DEPTH];
  logic [DIG_W-1:0]   stack_nxt [DEPTH];
  logic [DCNT_W-1:0]  dig_cnt_r;
  logic [DCNT_W-1:0]  dig_cnt_nxt;
  logic               push;

  // Output register.
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_symbol_r;
  logic               out_last_r;

  logic [2*CFG_DATA_W-1:0] alpha_all;
  logic [SYM_W-1:0]        sym [ALPHA_SYMS];
  logic                    alpha_ok;
  logic [VALUE_BITS-1:0]   value_u;
  logic [VALUE_BITS-1:0]   mag_abs;
  logic                    chunk_last;
  logic                    out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r  <= '0;
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SIZE:  base_size_r  <= cfg_data[RADIX_W-1:0];
        CFG_ALPHA_LOW:  alpha_low_r  <= cfg_data;
        CFG_ALPHA_HIGH: alpha_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the alphabet into its symbols.
  assign alpha_all = {alpha_high_r, alpha_low_r};

  always_comb begin
    for (int i = 0; i < ALPHA_SYMS; i++) begin
      sym[i] = alpha_all[SYM_W*i +: SYM_W];
    end
  end

  // Alphabet check: radix in range, no reserved bytes, no duplicates among used symbols.
  always_comb begin
    alpha_ok = (base_size_r >= MIN_RADIX) && (base_size_r <= RADIX_W'(MAX_BASE));
    for (int i = 0; i < ALPHA_SYMS; i++) begin
      if (RADIX_W'(i) < base_size_r) begin
        if (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < ALPHA_SYMS; j++) begin
          if (RADIX_W'(j) < base_size_r && sym[i] == sym[j]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Magnitude of the incoming value; the most negative value maps to 2^(n-1).
  assign value_u = in_value;
  assign mag_abs = in_value[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

  // One chunk of restoring division by the radix: the quotient bits shift in
  // at the bottom while the dividend bits leave at the top.
  always_comb begin
    logic [RADIX_W-1:0]   part;
    logic [DIG_W-1:0]     rem_v;
    logic [STEP_BITS-1:0] top;
    logic [STEP_BITS-1:0] qbits;
    top   = mag_r[MAG_W-1 -: STEP_BITS];
    rem_v = rem_r;
    qbits = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      part = RADIX_W'({rem_v, top[STEP_BITS-1-k]});
      if (part >= base_size_r) begin
        qbits[STEP_BITS-1-k] = 1'b1;
        part = part - base_size_r;
      end
      rem_v = part[DIG_W-1:0];
    end
    rem_nxt = rem_v;
    mag_nxt = (mag_r << STEP_BITS) | MAG_W'(qbits);
  end

  assign chunk_last = (chunk_r == CHUNK_W'(CHUNKS - 1));
  assign push       = cmd.div_step && chunk_last;

  // Division control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (cmd.load || push) begin
      chunk_r <= '0;
    end else if (cmd.div_step) begin
      chunk_r <= chunk_r + CHUNK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= MAG_W'(mag_abs);
      rem_r <= '0;
      neg_r <= in_value[VALUE_BITS-1];
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
      rem_r <= push ? '0 : rem_nxt;
    end
  end

  // Digit stack: digits come out least significant first and leave from the top.
  always_comb begin
    stack_nxt   = stack_r;
    dig_cnt_nxt = dig_cnt_r;
    if (cmd.load) begin
      dig_cnt_nxt = '0;
    end else if (push) begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        stack_nxt[k] = stack_r[k-1];
      end
      stack_nxt[0] = rem_nxt;
      dig_cnt_nxt  = dig_cnt_r + DCNT_W'(1);
    end else if (cmd.emit_digit) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        stack_nxt[k] = stack_r[k+1];
      end
      dig_cnt_nxt = dig_cnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_cnt_r <= '0;
    end else begin
      dig_cnt_r <= dig_cnt_nxt;
    end
  end

  // Output register; a new word loads as soon as the held one is taken.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_symbol_r <= CHAR_MINUS;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_symbol_r <= sym[SYM_IDX_W'(stack_r[0])];
      out_last_r   <= (dig_cnt_r == DCNT_W'(1));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  // Status to the controller.
  always_comb begin
    sts.alpha_ok   = alpha_ok;
    sts.neg        = neg_r;
    sts.chunk_last = chunk_last;
    sts.quot_zero  = (mag_nxt == '0);
    sts.out_free   = out_free;
    sts.one_left   = (dig_cnt_r == DCNT_W'(1));
  end

endmodule

// File: hw/rtl/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                              Word
// in        input      in_valid, in_ready, in_value       one signed value
// out       output     out_valid, out_ready, out_symbol,  one text symbol
//                      out_last
// cfg       input      cfg_valid, cfg_ready, cfg_index,   one register write
//                      cfg_data
//
// Each digit passes all ceil(VALUE_BITS/8) chunks of the magnitude through the shared
// remainder divider, which retires 8 dividend bits per cycle.
// A value is loaded and divided digit by digit; its symbols then leave one per cycle
// while out_ready does not stall the output register.
// Reset (rst_n low, synchronous) clears the registers to radix 0, which
// drops every value, and empties the output register.
// Stalls on out_ready hold the symbol in the output register; the next value
// is accepted once the last symbol has been loaded, while it still waits.

module integer_to_radix_digits #(
  parameter int MAX_BASE   = itrd_pkg::MAX_BASE_DEF,
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VALUE_BITS-1:0]     in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itrd_pkg::SYM_W-1:0]       out_symbol,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import itrd_pkg::*;

  itrd_cmd_t cmd;
  itrd_sts_t sts;
  logic      cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  // Sequencer.
  itrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready)
  );

  // Registers, divider, digit stack and output register.
  itrd_dp #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_value   (in_value),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

`ifndef ASSERT_OFF
  // A value accepted with a usable alphabet keeps the input closed next cycle.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.alpha_ok) |=> !in_ready)
    else $error("input reopened right after a value was loaded");

  // Within a run, the next symbol follows a taken one without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a symbol run");

  // A new value is only taken once the previous run has reached its last symbol.
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_last))
    else $error("value accepted while a run was still open");
`endif

endmodule

// File: sim/integer_to_radix_digits_test.sv
`timescale 1ns / 1ps

module integer_to_radix_digits_test;
  import itrd_pkg::*;

  // Spare register index; the block ignores writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Cycles with no word moved on any channel before the run is abandoned.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles that cover the slowest conversion (radix 2).
  localparam int DRAIN_CYCLES = 200;
  // Input words sent while the alphabet is valid in the random part.
  localparam int RANDOM_ITEMS = 350;

  typedef enum logic [1:0] {ROW_SETUP, ROW_TYPED, ROW_CHECKED} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [4:0]  size;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] value;
  } stimulus_row_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [31:0]      in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SYM_W-1:0]        out_symbol;
  logic                    out_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Copy of the configuration as the block should hold it.
  logic [4:0]              radix_now = '0;
  logic [127:0]            alphabet_now = '0;

  symbol_word_t            expected_symbols[$];
  stimulus_row_t           directed_rows[$];
  string                   directed_text[$];
  int                      text_row = -1;
  int                      failures = 0;
  int                      idle_cycles = 0;
  int                      ready_hold = 0;

  integer_to_radix_digits uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Queue the text one value should produce under the current alphabet.
  function automatic void predict_symbols(input logic [31:0] value);
    logic [31:0]      mag;
    logic [31:0]      radix;
    logic [SYM_W-1:0] digit_text[$];
    bit               usable;
    int               i;
    int               j;
    usable = (radix_now >= MIN_RADIX) && (radix_now <= MAX_BASE_DEF);
    if (!usable) begin
      return;
    end
    for (i = 0; i < radix_now; i++) begin
      if (alphabet_now[8*i +: 8] inside {CHAR_NUL, CHAR_PLUS, CHAR_MINUS}) begin
        usable = 0;
      end
      for (j = i + 1; j < radix_now; j++) begin
        if (alphabet_now[8*j +: 8] == alphabet_now[8*i +: 8]) begin
          usable = 0;
        end
      end
    end
    if (!usable) begin
      return;
    end
    // The most negative value negates to its true magnitude in 32 unsigned bits.
    radix = 32'(radix_now);
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      digit_text.push_front(alphabet_now[8*(mag % radix) +: 8]);
      mag = mag / radix;
    end while (mag != 0);
    if (value[31]) begin
      expected_symbols.push_back({CHAR_MINUS, 1'b0});
    end
    for (i = 0; i < digit_text.size(); i++) begin
      expected_symbols.push_back({digit_text[i], i == digit_text.size() - 1});
    end
  endfunction

  function automatic void add_setup(input logic [4:0] size, input logic [63:0] lo,
                                    input logic [63:0] hi);
    stimulus_row_t row;
    row = '{kind: ROW_SETUP, size: size, lo: lo, hi: hi, value: '0};
    directed_rows.push_back(row);
    directed_text.push_back("");
  endfunction

  function automatic void add_typed(input logic [31:0] value, input string text);
    stimulus_row_t row;
    row = '{kind: ROW_TYPED, size: '0, lo: '0, hi: '0, value: value};
    directed_rows.push_back(row);
    directed_text.push_back(text);
  endfunction

  function automatic void add_checked(input logic [31:0] value);
    stimulus_row_t row;
    row = '{kind: ROW_CHECKED, size: '0, lo: '0, hi: '0, value: value};
    directed_rows.push_back(row);
    directed_text.push_back("");
  endfunction

  // Send one value word; row selects typed text, or the predictor when negative.
  task automatic send_value(input logic [31:0] value, input int row);
    in_valid <= 1'b1;
    in_value <= value;
    text_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write one register; cfg_valid stays high so writes can run back to back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all three registers, with junk above the radix field, sometimes after a spare write.
  task automatic load_alphabet(input logic [4:0] size, input logic [63:0] lo,
                               input logic [63:0] hi);
    logic [63:0] size_word;
    size_word = {$urandom, $urandom};
    size_word[4:0] = size;
    if ($urandom_range(0, 3) == 0) begin
      write_register(CFG_SPARE, {$urandom, $urandom});
    end
    write_register(CFG_ALPHA_LOW, lo);
    write_register(CFG_BASE_SIZE, size_word);
    write_register(CFG_ALPHA_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every expected symbol is in, then let the block settle.
  // It first waits on the clock so the checker has queued the last accepted word.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The receiver mixes short stalls with ready stretches, both of random length.
  always @(posedge clk) begin
    logic ready_next;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_next = ($urandom_range(0, 2) != 0);
      out_ready <= ready_next;
      ready_hold <= ready_next ? $urandom_range(0, 40) : $urandom_range(0, 6);
    end
  end

  // Check results, track register writes and queue expectations per accepted word.
  always @(posedge clk) begin
    symbol_word_t head;
    int           k;
    if (rst_n) begin
      // Output is checked first so a word arriving with a new input never matches it.
      if (out_valid && out_ready) begin
        if (expected_symbols.size() == 0) begin
          $error("symbol %h (last %b) arrived with nothing expected", out_symbol, out_last);
          failures++;
        end else begin
          head = expected_symbols.pop_front();
          if (out_symbol !== head.symbol) begin
            $error("symbol: expected %h, got %h", head.symbol, out_symbol);
            failures++;
          end
          if (out_last !== head.last) begin
            $error("last: expected %b, got %b", head.last, out_last);
            failures++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_SIZE:  radix_now = cfg_data[4:0];
          CFG_ALPHA_LOW:  alphabet_now[63:0] = cfg_data;
          CFG_ALPHA_HIGH: alphabet_now[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (text_row >= 0) begin
          for (k = 0; k < directed_text[text_row].len(); k++) begin
            expected_symbols.push_back({directed_text[text_row][k],
                                        k == directed_text[text_row].len() - 1});
          end
        end else begin
          predict_symbols(in_value);
        end
      end
      // Watchdog on cycles in which no word moves anywhere.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    stimulus_row_t row;
    logic [127:0]  alpha;
    logic [255:0]  taken;
    logic [7:0]    c;
    logic [31:0]   value;
    int            size;
    int            sel;
    int            i;
    int            j;
    int            count;
    int            burst_left;
    int            valid_items;
    bit            broken;

    // Registers still hold their reset values, which drop every value.
    add_typed(32'd0, "");
    add_typed(32'h8000_0000, "");
    add_typed(32'h7FFF_FFFF, "");
    // Decimal, with forbidden and repeated bytes in the unused slots.
    add_setup(5'd10, 64'h3736_3534_3332_3130, 64'hFF00_392B_2D00_3938);
    add_typed(32'd0, "0");
    add_typed(32'h7FFF_FFFF, "2147483647");
    add_typed(32'h8000_0000, "-2147483648");
    add_typed(-32'sd1, "-1");
    add_checked(32'd1234567);
    add_checked(-32'sd987654321);
    // Full sixteen-symbol alphabet.
    add_setup(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    add_typed(32'h8000_0000, "-80000000");
    add_typed(32'h7FFF_FFFF, "7FFFFFFF");
    add_checked(32'hA5A5_5A5A);
    // Binary gives the longest runs.
    add_setup(5'd2, 64'h2D2B_00FF_0031_3130, 64'h0);
    add_checked(32'h8000_0000);
    add_checked(32'h7FFF_FFFF);
    add_checked(32'd5);
    // Broken alphabets: repeated symbol, plus, minus, zero byte, radix 1 and 17.
    add_setup(5'd16, 64'h3736_3534_3332_3130, 64'h4145_4443_4241_3938);
    add_typed(-32'sd5, "");
    add_setup(5'd3, 64'h0000_0000_002B_3130, 64'h0);
    add_typed(32'd7, "");
    add_setup(5'd4, 64'h0000_0000_2D32_3130, 64'h0);
    add_typed(-32'sd7, "");
    add_setup(5'd5, 64'h0000_0000_3332_3130, 64'h0);
    add_typed(32'd123, "");
    add_setup(5'd1, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    add_typed(32'd1, "");
    add_setup(5'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    add_typed(32'd100, "");
    // Radix nine, back to a valid alphabet after the broken ones.
    add_setup(5'd9, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_2D38);
    add_checked(-32'sd1000);
    add_checked(32'd80);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: setup rows drain the block before writing registers.
    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_SETUP: begin
          wait_for_idle();
          load_alphabet(row.size, row.lo, row.hi);
        end
        ROW_TYPED: send_value(row.value, i);
        default:   send_value(row.value, -1);
      endcase
    end

    // Random phases, each with a fresh alphabet; a few are deliberately broken.
    valid_items = 0;
    burst_left = 0;
    while (valid_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 7);
      size = (sel == 1) ? 2 : (sel == 2) ? 16 : $urandom_range(2, 16);
      alpha = {$urandom, $urandom, $urandom, $urandom};
      taken = '0;
      for (i = 0; i < size; i++) begin
        do c = 8'($urandom_range(1, 255));
        while (c == CHAR_PLUS || c == CHAR_MINUS || taken[c]);
        taken[c] = 1'b1;
        alpha[8*i +: 8] = c;
      end
      broken = (sel == 0);
      if (broken) begin
        case ($urandom_range(0, 2))
          0: size = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
          1: begin
            i = $urandom_range(1, size - 1);
            j = $urandom_range(0, i - 1);
            alpha[8*i +: 8] = alpha[8*j +: 8];
          end
          default: begin
            i = $urandom_range(0, size - 1);
            case ($urandom_range(0, 2))
              0:       alpha[8*i +: 8] = CHAR_NUL;
              1:       alpha[8*i +: 8] = CHAR_PLUS;
              default: alpha[8*i +: 8] = CHAR_MINUS;
            endcase
          end
        endcase
      end
      wait_for_idle();
      load_alphabet(5'(size), alpha[63:0], alpha[127:64]);
      count = broken ? $urandom_range(4, 10) : $urandom_range(20, 45);
      if (!broken) begin
        valid_items += count;
      end
      for (j = 0; j < count; j++) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          value = 32'h8000_0000;
        end else if (sel == 1) begin
          value = 32'h7FFF_FFFF;
        end else if (sel == 2) begin
          value = 32'd0;
        end else begin
          // Shifting spreads magnitudes over every digit count.
          value = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) begin
            value = -value;
          end
        end
        send_value(value, -1);
        // Bursts end in a random gap; some bursts run long with no gap at all.
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end

    wait_for_idle();
    if (failures == 0 && expected_symbols.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
